// ===== hw/rtl/radio_neighbor_table_assert.svh =====
// assertion macros used by the neighbor table controller
`ifndef RADIO_NEIGHBOR_TABLE_ASSERT_SVH
`define RADIO_NEIGHBOR_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock outside reset
`define RNT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("neighbor table assertion failed");
// expression must never be true outside reset
`define RNT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("neighbor table assertion failed");
`else
`define RNT_ASSERT(label, clk, rstn, prop)
`define RNT_NEVER(label, clk, rstn, expr)
`endif
`endif

// ===== hw/rtl/rnt_pkg.sv =====
package rnt_pkg;

    localparam int TABLE_SIZE_DEF = 16;
    localparam int PINNED_MAX_DEF = 4;
    localparam int MAX_RESULTS    = 16;
    localparam int LIM_W          = 5;
    localparam int PIN_REGS       = 4;
    localparam int SLOT_W         = 4;
    localparam int ID_W           = 24;
    localparam int TIME_W         = 32;
    localparam int RSSI_W         = 8;
    localparam int MARGIN_W       = 7;
    localparam int PCOUNT_W       = 3;
    localparam int AVG_SUM_W      = 11;
    localparam int CMP_W          = 10;

    localparam logic [31:0] STALE_RST  = 32'd10000;
    localparam logic [6:0]  MARGIN_RST = 7'd6;

    localparam logic OP_UPSERT = 1'b0;
    localparam logic OP_SNAP   = 1'b1;

    typedef enum logic [2:0] {
        REG_PCOUNT = 3'd0,
        REG_PIN_A  = 3'd1,
        REG_PIN_B  = 3'd2,
        REG_PIN_C  = 3'd3,
        REG_PIN_D  = 3'd4,
        REG_STALE  = 3'd5,
        REG_MARGIN = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        OC_UPDATED   = 3'd0,
        OC_INSERTED  = 3'd1,
        OC_STALE     = 3'd2,
        OC_WEAKEST   = 3'd3,
        OC_UNTRACKED = 3'd4,
        OC_ENTRY     = 3'd5,
        OC_NONE      = 3'd6
    } outc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DEC,
        ST_PICK,
        ST_EMIT,
        ST_FIN
    } st_t;

    typedef struct packed {
        logic [PCOUNT_W-1:0]            pcount;
        logic [PIN_REGS-1:0][ID_W-1:0]  pin_id;
        logic [TIME_W-1:0]              stale;
        logic [MARGIN_W-1:0]            margin;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [TIME_W-1:0]        htime;
        logic signed [RSSI_W-1:0] avg;
    } ent_t;

    typedef struct packed {
        outc_t                    outcome;
        logic [SLOT_W-1:0]        slot;
        logic [ID_W-1:0]          id;
        logic [TIME_W-1:0]        age;
        logic signed [RSSI_W-1:0] avg;
        logic                     last;
    } res_t;

endpackage

// ===== hw/rtl/rnt_mem.sv =====
module rnt_mem #(
    parameter int DEPTH = rnt_pkg::TABLE_SIZE_DEF,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  rnt_pkg::ent_t wdata,
    input  logic [AW-1:0] raddr,
    output rnt_pkg::ent_t rdata
);

    rnt_pkg::ent_t mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/rnt_cfg.sv =====
module rnt_cfg (
    input  logic          clk,
    input  logic          rstn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output rnt_pkg::cfg_t cfg
);

    rnt_pkg::cfg_t    cfg_reg;
    rnt_pkg::reg_idx_t idx;
    logic             wr;

    assign idx    = rnt_pkg::reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk) begin
        if (!rstn) begin
            cfg_reg.pcount <= '0;
            cfg_reg.pin_id <= '0;
            cfg_reg.stale  <= rnt_pkg::STALE_RST;
            cfg_reg.margin <= rnt_pkg::MARGIN_RST;
        end else if (wr) begin
            unique case (idx)
                rnt_pkg::REG_PCOUNT: cfg_reg.pcount    <= pwdata[rnt_pkg::PCOUNT_W-1:0];
                rnt_pkg::REG_PIN_A:  cfg_reg.pin_id[0] <= pwdata[rnt_pkg::ID_W-1:0];
                rnt_pkg::REG_PIN_B:  cfg_reg.pin_id[1] <= pwdata[rnt_pkg::ID_W-1:0];
                rnt_pkg::REG_PIN_C:  cfg_reg.pin_id[2] <= pwdata[rnt_pkg::ID_W-1:0];
                rnt_pkg::REG_PIN_D:  cfg_reg.pin_id[3] <= pwdata[rnt_pkg::ID_W-1:0];
                rnt_pkg::REG_STALE:  cfg_reg.stale     <= pwdata;
                rnt_pkg::REG_MARGIN: cfg_reg.margin    <= pwdata[rnt_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        prdata = '0;
        unique case (idx)
            rnt_pkg::REG_PCOUNT: prdata = 32'(cfg_reg.pcount);
            rnt_pkg::REG_PIN_A:  prdata = 32'(cfg_reg.pin_id[0]);
            rnt_pkg::REG_PIN_B:  prdata = 32'(cfg_reg.pin_id[1]);
            rnt_pkg::REG_PIN_C:  prdata = 32'(cfg_reg.pin_id[2]);
            rnt_pkg::REG_PIN_D:  prdata = 32'(cfg_reg.pin_id[3]);
            rnt_pkg::REG_STALE:  prdata = cfg_reg.stale;
            rnt_pkg::REG_MARGIN: prdata = 32'(cfg_reg.margin);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/rnt_ctrl.sv =====
`include "radio_neighbor_table_assert.svh"

module rnt_ctrl #(
    parameter int TABLE_SIZE = rnt_pkg::TABLE_SIZE_DEF,
    parameter int PINNED_MAX = rnt_pkg::PINNED_MAX_DEF,
    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
    input  logic                    clk,
    input  logic                    rstn,
    input  rnt_pkg::cfg_t           cfg,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_op,
    input  logic [23:0]             s_id,
    input  logic [31:0]             s_now,
    input  logic signed [7:0]       s_rssi,
    input  logic [31:0]             s_fresh,
    input  logic [7:0]              s_max,
    output logic                    m_valid,
    input  logic                    m_ready,
    output rnt_pkg::res_t           m_res,
    output logic [IDX_W-1:0]        rd_addr,
    input  rnt_pkg::ent_t           rd_data,
    output logic                    we,
    output logic [IDX_W-1:0]        wr_addr,
    output rnt_pkg::ent_t           wr_data
);

    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int PW    = (PINNED_MAX > 1) ? $clog2(PINNED_MAX) : 1;
    localparam int SW    = rnt_pkg::SLOT_W;
    localparam int LW    = rnt_pkg::LIM_W;
    localparam int AW    = rnt_pkg::AVG_SUM_W;
    localparam int CW    = rnt_pkg::CMP_W;

    rnt_pkg::st_t st_reg, st_next;

    // latched item
    logic              op_reg;
    logic [23:0]       id_reg;
    logic [31:0]       now_reg;
    logic signed [7:0] rssi_reg;
    logic [31:0]       fresh_reg;
    logic [LW-1:0]     lim_reg;
    logic [LW-1:0]     lim_in;

    // scan pipeline
    logic [CNT_W-1:0]  a_reg;
    logic              ev_vld_reg;
    logic [IDX_W-1:0]  ev_idx_reg;
    logic              issue, ev, done;

    logic [TABLE_SIZE-1:0] used_reg, taken_reg;

    // search results
    logic              m_f_reg, f_f_reg, s_f_reg, w_f_reg, b_f_reg;
    logic [IDX_W-1:0]  m_idx_reg, f_idx_reg, s_idx_reg, w_idx_reg, b_idx_reg;
    logic signed [7:0] m_avg_reg, w_avg_reg, b_avg_reg;
    logic [31:0]       s_age_reg, b_age_reg;
    logic [23:0]       b_id_reg;
    logic [PINNED_MAX-1:0] pf_reg;
    logic [IDX_W-1:0]  pslot_reg [PINNED_MAX];
    logic [31:0]       page_reg  [PINNED_MAX];
    logic signed [7:0] pavg_reg  [PINNED_MAX];

    logic              tk_m, tk_f, tk_s, tk_w, tk_b;
    logic [PINNED_MAX-1:0] tk_l;
    logic              e_used, e_pin;
    logic [31:0]       e_age;

    // emit control
    logic [LW-1:0]     n_reg;
    logic [2:0]        p_reg;
    logic [2:0]        pins;
    logic              pend_vld_reg;
    rnt_pkg::res_t     pend_reg, cand, out_data, dec_res, out_reg;
    logic              m_valid_reg, out_free, out_push;
    logic              pend_load, n_inc, p_inc, taken_set, scan_clr, accept;
    logic              lane_ok;
    logic [PW-1:0]     li;

    // decision logic
    logic signed [AW-1:0] sx, sum, q;
    logic signed [7:0]    navg;
    logic                 beats;
    logic                 dec_we;
    logic [IDX_W-1:0]     dec_idx;
    rnt_pkg::ent_t        dec_ent;

    assign s_ready  = (st_reg == rnt_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_res    = out_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign lim_in   = (s_max > 8'(rnt_pkg::MAX_RESULTS)) ? LW'(rnt_pkg::MAX_RESULTS)
                                                         : s_max[LW-1:0];
    assign pins     = (cfg.pcount > 3'(PINNED_MAX)) ? 3'(PINNED_MAX) : cfg.pcount;

    // read address walk over the table
    assign issue   = (st_reg == rnt_pkg::ST_SCAN) && (a_reg != CNT_W'(TABLE_SIZE));
    assign ev      = (st_reg == rnt_pkg::ST_SCAN) && ev_vld_reg;
    assign done    = ev && (a_reg == CNT_W'(TABLE_SIZE));
    assign rd_addr = a_reg[IDX_W-1:0];

    // per-entry evaluation of the word read back
    always_comb begin
        e_used = used_reg[ev_idx_reg];
        e_age  = now_reg - rd_data.htime;
        e_pin  = 1'b0;
        for (int p = 0; p < PINNED_MAX; p++) begin
            if (3'(p) < cfg.pcount && cfg.pin_id[p] == rd_data.id) begin
                e_pin = 1'b1;
            end
        end
        tk_m = ev && e_used && rd_data.id == id_reg && !m_f_reg;
        tk_f = ev && !e_used && !f_f_reg;
        tk_s = ev && e_age >= cfg.stale && (!s_f_reg || e_age > s_age_reg);
        tk_w = ev && !e_pin && (!w_f_reg || rd_data.avg < w_avg_reg);
        tk_b = ev && e_used && !taken_reg[ev_idx_reg] && e_age < fresh_reg
               && (!b_f_reg || rd_data.avg > b_avg_reg);
        for (int p = 0; p < PINNED_MAX; p++) begin
            tk_l[p] = ev && 3'(p) < cfg.pcount && e_used
                      && rd_data.id == cfg.pin_id[p] && !pf_reg[p];
        end
    end

    // upsert decision: update, free slot, stale, weakest, or untracked
    always_comb begin
        sx    = AW'(m_avg_reg);
        sum   = (sx <<< 3) - sx + AW'(rssi_reg);
        q     = (sum < 0) ? ((sum + AW'(7)) >>> 3) : (sum >>> 3);
        navg  = q[7:0];
        beats = CW'(rssi_reg) > (CW'(w_avg_reg) + $signed(CW'(cfg.margin)));
        dec_we  = 1'b1;
        dec_idx = '0;
        dec_ent.id    = id_reg;
        dec_ent.htime = now_reg;
        dec_ent.avg   = rssi_reg;
        dec_res       = '0;
        dec_res.id    = id_reg;
        dec_res.last  = 1'b1;
        if (m_f_reg) begin
            dec_idx         = m_idx_reg;
            dec_ent.avg     = navg;
            dec_res.outcome = rnt_pkg::OC_UPDATED;
        end else if (f_f_reg) begin
            dec_idx         = f_idx_reg;
            dec_res.outcome = rnt_pkg::OC_INSERTED;
        end else if (s_f_reg) begin
            dec_idx         = s_idx_reg;
            dec_res.outcome = rnt_pkg::OC_STALE;
        end else if (w_f_reg && beats) begin
            dec_idx         = w_idx_reg;
            dec_res.outcome = rnt_pkg::OC_WEAKEST;
        end else begin
            dec_we          = 1'b0;
            dec_res.outcome = rnt_pkg::OC_UNTRACKED;
        end
        dec_res.slot = dec_we ? SW'(dec_idx) : '0;
        dec_res.avg  = dec_we ? dec_ent.avg : '0;
    end

    // pinned lane candidate
    always_comb begin
        li      = p_reg[PW-1:0];
        lane_ok = pf_reg[li] && (page_reg[li] < fresh_reg);
    end

    // state machine: next state and control strobes
    always_comb begin
        st_next   = st_reg;
        out_push  = 1'b0;
        out_data  = pend_reg;
        cand      = '0;
        pend_load = 1'b0;
        n_inc     = 1'b0;
        p_inc     = 1'b0;
        taken_set = 1'b0;
        scan_clr  = 1'b0;
        we        = 1'b0;
        wr_addr   = dec_idx;
        wr_data   = dec_ent;
        unique case (st_reg)
            rnt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    scan_clr = 1'b1;
                    if (s_op == rnt_pkg::OP_SNAP && lim_in == '0) begin
                        st_next = rnt_pkg::ST_FIN;
                    end else begin
                        st_next = rnt_pkg::ST_SCAN;
                    end
                end
            end
            rnt_pkg::ST_SCAN: begin
                if (done) begin
                    if (op_reg == rnt_pkg::OP_UPSERT) begin
                        st_next = rnt_pkg::ST_DEC;
                    end else if (pins != '0) begin
                        st_next = rnt_pkg::ST_EMIT;
                    end else begin
                        st_next = rnt_pkg::ST_PICK;
                    end
                end
            end
            rnt_pkg::ST_DEC: begin
                if (out_free) begin
                    out_push = 1'b1;
                    out_data = dec_res;
                    we       = dec_we;
                    st_next  = rnt_pkg::ST_IDLE;
                end
            end
            rnt_pkg::ST_PICK: begin
                if (!b_f_reg) begin
                    st_next = rnt_pkg::ST_FIN;
                end else if (!pend_vld_reg || out_free) begin
                    cand.outcome = rnt_pkg::OC_ENTRY;
                    cand.slot    = SW'(b_idx_reg);
                    cand.id      = b_id_reg;
                    cand.age     = b_age_reg;
                    cand.avg     = b_avg_reg;
                    pend_load    = 1'b1;
                    out_push     = pend_vld_reg;
                    taken_set    = 1'b1;
                    n_inc        = 1'b1;
                    if (n_reg + LW'(1) == lim_reg) begin
                        st_next = rnt_pkg::ST_FIN;
                    end else begin
                        scan_clr = 1'b1;
                        st_next  = rnt_pkg::ST_SCAN;
                    end
                end
            end
            rnt_pkg::ST_EMIT: begin
                if (p_reg == pins || n_reg == lim_reg) begin
                    st_next = rnt_pkg::ST_FIN;
                end else if (!lane_ok) begin
                    p_inc = 1'b1;
                end else if (!pend_vld_reg || out_free) begin
                    cand.outcome = rnt_pkg::OC_ENTRY;
                    cand.slot    = SW'(pslot_reg[li]);
                    cand.id      = cfg.pin_id[li];
                    cand.age     = page_reg[li];
                    cand.avg     = pavg_reg[li];
                    pend_load    = 1'b1;
                    out_push     = pend_vld_reg;
                    n_inc        = 1'b1;
                    p_inc        = 1'b1;
                end
            end
            rnt_pkg::ST_FIN: begin
                if (out_free) begin
                    out_push = 1'b1;
                    if (pend_vld_reg) begin
                        out_data      = pend_reg;
                        out_data.last = 1'b1;
                    end else begin
                        out_data         = '0;
                        out_data.outcome = rnt_pkg::OC_NONE;
                        out_data.last    = 1'b1;
                    end
                    st_next = rnt_pkg::ST_IDLE;
                end
            end
            default: st_next = rnt_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk) begin
        if (!rstn) begin
            st_reg       <= rnt_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            used_reg     <= '0;
            taken_reg    <= '0;
            a_reg        <= '0;
            ev_vld_reg   <= 1'b0;
            m_f_reg      <= 1'b0;
            f_f_reg      <= 1'b0;
            s_f_reg      <= 1'b0;
            w_f_reg      <= 1'b0;
            b_f_reg      <= 1'b0;
            pf_reg       <= '0;
            n_reg        <= '0;
            p_reg        <= '0;
            lim_reg      <= '0;
            pend_vld_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            // output word register
            if (out_push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (we) begin
                used_reg[wr_addr] <= 1'b1;
            end
            if (accept) begin
                taken_reg    <= '0;
                n_reg        <= '0;
                p_reg        <= '0;
                lim_reg      <= lim_in;
                pend_vld_reg <= 1'b0;
            end else begin
                if (taken_set) taken_reg[b_idx_reg] <= 1'b1;
                if (n_inc)     n_reg <= n_reg + LW'(1);
                if (p_inc)     p_reg <= p_reg + 3'd1;
                if (pend_load) pend_vld_reg <= 1'b1;
            end
            // scan counters and found flags
            if (scan_clr) begin
                a_reg      <= '0;
                ev_vld_reg <= 1'b0;
                m_f_reg    <= 1'b0;
                f_f_reg    <= 1'b0;
                s_f_reg    <= 1'b0;
                w_f_reg    <= 1'b0;
                b_f_reg    <= 1'b0;
                pf_reg     <= '0;
            end else begin
                ev_vld_reg <= issue;
                if (issue) a_reg <= a_reg + CNT_W'(1);
                if (tk_m) m_f_reg <= 1'b1;
                if (tk_f) f_f_reg <= 1'b1;
                if (tk_s) s_f_reg <= 1'b1;
                if (tk_w) w_f_reg <= 1'b1;
                if (tk_b) b_f_reg <= 1'b1;
                pf_reg <= pf_reg | tk_l;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk) begin
        ev_idx_reg <= a_reg[IDX_W-1:0];
        if (accept) begin
            op_reg    <= s_op;
            id_reg    <= s_id;
            now_reg   <= s_now;
            rssi_reg  <= s_rssi;
            fresh_reg <= s_fresh;
        end
        if (out_push) out_reg <= out_data;
        if (pend_load) pend_reg <= cand;
        if (tk_m) begin
            m_idx_reg <= ev_idx_reg;
            m_avg_reg <= rd_data.avg;
        end
        if (tk_f) f_idx_reg <= ev_idx_reg;
        if (tk_s) begin
            s_idx_reg <= ev_idx_reg;
            s_age_reg <= e_age;
        end
        if (tk_w) begin
            w_idx_reg <= ev_idx_reg;
            w_avg_reg <= rd_data.avg;
        end
        if (tk_b) begin
            b_idx_reg <= ev_idx_reg;
            b_id_reg  <= rd_data.id;
            b_age_reg <= e_age;
            b_avg_reg <= rd_data.avg;
        end
        for (int p = 0; p < PINNED_MAX; p++) begin
            if (tk_l[p]) begin
                pslot_reg[p] <= ev_idx_reg;
                page_reg[p]  <= e_age;
                pavg_reg[p]  <= rd_data.avg;
            end
        end
    end

    `RNT_ASSERT(a_push_room, clk, rstn, out_push |-> (!m_valid_reg || m_ready))
    `RNT_ASSERT(a_count_limit, clk, rstn, n_reg <= lim_reg)
    `RNT_ASSERT(a_write_ends, clk, rstn, we |=> (st_reg == rnt_pkg::ST_IDLE))
    `RNT_ASSERT(a_one_item, clk, rstn, accept |=> !s_ready)
    `RNT_NEVER(a_pick_found, clk, rstn, taken_set && !b_f_reg)

endmodule

// ===== hw/rtl/radio_neighbor_table.sv =====
// Radio neighbor table. Entries (id, last-heard time, rssi average) live in one
// synchronous memory with a single read port; every item but a snapshot with a
// zero limit walks the whole table through that port, one entry per cycle. An
// upsert writes the chosen slot back at its end, when its result is pushed out.
// A snapshot with pinned ids makes one walk and then reports the fresh pinned
// ids that it found; strongest-first takes one walk per reported entry.
// Results leave through an output register, and each word carries last on the
// final result of its item. Configuration must be written over the APB port
// only while no item is in flight; the block itself does not enforce this.
module radio_neighbor_table #(
    parameter int TABLE_SIZE = rnt_pkg::TABLE_SIZE_DEF,
    parameter int PINNED_MAX = rnt_pkg::PINNED_MAX_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [23:0]        s_node_id,
    input  logic [31:0]        s_now_ms,
    input  logic signed [7:0]  s_rssi,
    input  logic [31:0]        s_fresh_ms,
    input  logic [7:0]         s_max_out,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_outcome,
    output logic [3:0]         m_slot,
    output logic [23:0]        m_entry_id,
    output logic [31:0]        m_age_ms,
    output logic signed [7:0]  m_rssi_avg,
    output logic               m_last
);

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    rnt_pkg::cfg_t    cfg;
    rnt_pkg::res_t    res;
    rnt_pkg::ent_t    rd_data, wr_data;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             we;

    // configuration registers
    rnt_cfg u_cfg (
        .clk     (aclk),
        .rstn    (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // table storage
    rnt_mem #(
        .DEPTH (TABLE_SIZE),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (aclk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // sequencer
    rnt_ctrl #(
        .TABLE_SIZE (TABLE_SIZE),
        .PINNED_MAX (PINNED_MAX)
    ) u_ctrl (
        .clk     (aclk),
        .rstn    (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_operation),
        .s_id    (s_node_id),
        .s_now   (s_now_ms),
        .s_rssi  (s_rssi),
        .s_fresh (s_fresh_ms),
        .s_max   (s_max_out),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign m_outcome  = res.outcome;
    assign m_slot     = res.slot;
    assign m_entry_id = res.id;
    assign m_age_ms   = res.age;
    assign m_rssi_avg = res.avg;
    assign m_last     = res.last;

endmodule
